// ===== sv/cbr_pkg.sv =====
// Shared widths, limits, register indexes and structs of the frame repacker.
// Depends on nothing; used by cbr_size_div and cbr_frame_repacker.
`timescale 1ns / 1ps
`default_nettype none

package cbr_pkg;

  localparam int NUM_W     = 26;
  localparam int DEN_W     = 16;
  localparam int SIZE_W    = 13;
  localparam int ACC_W     = 16;
  localparam int BREF_W    = 14;
  localparam int BP_W      = 9;
  localparam int SIDE_W    = 6;
  localparam int DATA_W    = 14;
  localparam int HDR_W     = 32;
  localparam int CAP_W     = 14;
  localparam int WORK_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int CNT_W     = 4;

  localparam logic [SIZE_W-1:0] SIZE_MAX = 13'h1fff;
  localparam logic [BP_W-1:0]   BP_MAX   = 9'd511;
  localparam int                PAD_BIT  = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_HDR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_SID = 3'd4;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [ACC_W-1:0] acc;
  } size_req_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [ACC_W-1:0]  acc;
  } size_res_t;

endpackage

`default_nettype wire

// ===== sv/cbr_frame_repacker.sv =====
// Top level of the constant-bitrate frame repacker: sequencer and result register.
// Depends on cbr_pkg and cbr_size_div.
`timescale 1ns / 1ps
`default_nettype none

// Takes one audio frame at a time and gives one result per frame, preceded by
// up to min(MAX_EMPTY, 31) inserted empty frames when the frame's main data
// does not fit behind the running back reference. Each result costs one size
// search in cbr_size_div, which runs its 13-step restoring divider unless the
// accumulator step alone reaches the target, the denominator is zero or the
// quotient would not fit. A new frame is taken once the last result of the
// previous one sits in the output register. The user must write configuration
// through cfg_* only while no frame is in work; the block does not enforce
// it. cfg_ready is always high.
module cbr_frame_repacker #(
  parameter int MAX_EMPTY = 31
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [cbr_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [cbr_pkg::CFG_DAT_W-1:0]          cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [cbr_pkg::HDR_W-1:0]              in_header,
  input  wire logic [cbr_pkg::SIDE_W-1:0]             in_side_size,
  input  wire logic [cbr_pkg::DATA_W-1:0]             in_data_size,
  input  wire logic                                   in_last_frame,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [cbr_pkg::HDR_W-1:0]                   out_header,
  output logic [cbr_pkg::SIZE_W-1:0]                  out_frame_size,
  output logic signed [cbr_pkg::CAP_W-1:0]            out_data_capacity,
  output logic [cbr_pkg::BP_W-1:0]                    out_back_pointer,
  output logic [cbr_pkg::BREF_W-1:0]                  out_pad_previous,
  output logic [cbr_pkg::BREF_W-1:0]                  out_pad_tail,
  output logic                                        out_inserted_empty,
  output logic                                        out_last_result,
  output logic                                        out_overflow_flag
);

  localparam int EMPTY_CAP = (MAX_EMPTY < 31) ? MAX_EMPTY : 31;
  localparam int EMP_W     = $clog2(EMPTY_CAP + 1);
  localparam logic [EMP_W-1:0] EMPTY_LIM = EMP_W'(EMPTY_CAP);
  localparam int W = cbr_pkg::WORK_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_WAIT  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [cbr_pkg::NUM_W-1:0]   num_r;
  logic [cbr_pkg::DEN_W-1:0]   den_r;
  logic [cbr_pkg::SIZE_W-1:0]  normal_r;
  logic [cbr_pkg::HDR_W-1:0]   ehdr_r;
  logic [cbr_pkg::SIDE_W-1:0]  eside_r;

  logic [cbr_pkg::ACC_W-1:0]   acc_r;
  logic [cbr_pkg::BREF_W-1:0]  bref_r;
  logic [EMP_W-1:0]            empties_r;

  logic [cbr_pkg::HDR_W-1:0]   hdr_r;
  logic [cbr_pkg::SIDE_W-1:0]  side_r;
  logic [cbr_pkg::DATA_W-1:0]  dsize_r;
  logic                        last_r;
  logic [cbr_pkg::BP_W-1:0]    br_r;
  logic [cbr_pkg::BREF_W-1:0]  pad_r;

  logic                        out_valid_r;
  logic [cbr_pkg::HDR_W-1:0]   o_hdr_r;
  logic [cbr_pkg::SIZE_W-1:0]  o_size_r;
  logic [cbr_pkg::CAP_W-1:0]   o_cap_r;
  logic [cbr_pkg::BP_W-1:0]    o_bp_r;
  logic [cbr_pkg::BREF_W-1:0]  o_padp_r;
  logic [cbr_pkg::BREF_W-1:0]  o_padt_r;
  logic                        o_emp_r;
  logic                        o_last_r;
  logic                        o_ovf_r;

  logic                        in_xfer;
  logic                        cfg_xfer;
  logic                        slot_free;
  logic                        emit;
  logic                        div_start;
  logic                        div_done;
  cbr_pkg::size_req_t          div_req;
  cbr_pkg::size_res_t          div_res;

  logic signed [W-1:0]         cap_s;
  logic signed [W-1:0]         ecap_s;
  logic signed [W-1:0]         nb_s;
  logic signed [W-1:0]         bre_s;
  logic [W-1:0]                nbc;
  logic                        need_empty;
  logic                        ovf;
  logic                        pad_hit;
  logic [cbr_pkg::HDR_W-1:0]   hdr_sel;
  logic [cbr_pkg::HDR_W-1:0]   hdr_out;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign in_stall  = state_r != S_IDLE;
  assign in_xfer   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign emit      = state_r == S_EMIT && slot_free;
  assign div_start = state_r == S_START;

  assign div_req.num = num_r;
  assign div_req.den = den_r;
  assign div_req.acc = acc_r;

  cbr_size_div u_size_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .res   (div_res)
  );

  assign cap_s  = signed'(W'(div_res.size)) - signed'(W'(side_r)) - 16'sd4;
  assign ecap_s = signed'(W'(div_res.size)) - signed'(W'(eside_r)) - 16'sd4;
  assign nb_s   = signed'(W'(br_r)) + cap_s - signed'(W'(dsize_r));
  assign bre_s  = signed'(W'(br_r)) + ecap_s;
  assign need_empty = nb_s < 16'sd0 && empties_r < EMPTY_LIM;
  assign ovf        = nb_s < 16'sd0;
  assign nbc        = ovf ? '0 : W'(nb_s);
  assign pad_hit    = div_res.size != normal_r;
  assign hdr_sel    = need_empty ? ehdr_r : hdr_r;

  always_comb begin
    hdr_out                   = hdr_sel;
    hdr_out[cbr_pkg::PAD_BIT] = pad_hit;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_xfer) state_nxt = S_START;
      S_START: state_nxt = S_WAIT;
      S_WAIT:  if (div_done) state_nxt = S_EMIT;
      S_EMIT:  if (slot_free) state_nxt = need_empty ? S_START : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      bref_r      <= '0;
      empties_r   <= '0;
      num_r       <= 26'd18432000;
      den_r       <= 16'd44100;
      normal_r    <= 13'd417;
      ehdr_r      <= 32'd4294676480;
      eside_r     <= 6'd32;
    end else begin
      state_r <= state_nxt;
      if (cfg_xfer) begin
        case (cfg_index)
          cbr_pkg::CFG_NUM:       num_r    <= cfg_data[cbr_pkg::NUM_W-1:0];
          cbr_pkg::CFG_DEN:       den_r    <= cfg_data[cbr_pkg::DEN_W-1:0];
          cbr_pkg::CFG_NORMAL:    normal_r <= cfg_data[cbr_pkg::SIZE_W-1:0];
          cbr_pkg::CFG_EMPTY_HDR: ehdr_r   <= cfg_data[cbr_pkg::HDR_W-1:0];
          cbr_pkg::CFG_EMPTY_SID: eside_r  <= cfg_data[cbr_pkg::SIDE_W-1:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        empties_r <= '0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
        if (need_empty) begin
          acc_r     <= div_res.acc;
          empties_r <= empties_r + 1'b1;
        end else if (last_r) begin
          acc_r  <= '0;
          bref_r <= '0;
        end else begin
          acc_r  <= div_res.acc;
          bref_r <= nbc[cbr_pkg::BREF_W-1:0];
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold frame fields over all results of a frame; the clamped back pointer is reloaded after each inserted empty.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hdr_r   <= in_header;
      side_r  <= in_side_size;
      dsize_r <= in_data_size;
      last_r  <= in_last_frame;
      if (bref_r > cbr_pkg::BREF_W'(cbr_pkg::BP_MAX)) begin
        br_r  <= cbr_pkg::BP_MAX;
        pad_r <= bref_r - cbr_pkg::BREF_W'(cbr_pkg::BP_MAX);
      end else begin
        br_r  <= bref_r[cbr_pkg::BP_W-1:0];
        pad_r <= '0;
      end
    end else if (emit && need_empty) begin
      if (bre_s < 16'sd0) begin
        br_r  <= '0;
        pad_r <= '0;
      end else if (bre_s > signed'(W'(cbr_pkg::BP_MAX))) begin
        br_r  <= cbr_pkg::BP_MAX;
        pad_r <= cbr_pkg::BREF_W'(bre_s - signed'(W'(cbr_pkg::BP_MAX)));
      end else begin
        br_r  <= bre_s[cbr_pkg::BP_W-1:0];
        pad_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_hdr_r          <= hdr_out;
      o_size_r         <= div_res.size;
      o_cap_r          <= need_empty ? ecap_s[cbr_pkg::CAP_W-1:0] : cap_s[cbr_pkg::CAP_W-1:0];
      o_bp_r           <= br_r;
      o_padp_r         <= pad_r;
      o_padt_r         <= (!need_empty && last_r) ? nbc[cbr_pkg::BREF_W-1:0] : '0;
      o_emp_r          <= need_empty;
      o_last_r         <= !need_empty;
      o_ovf_r          <= !need_empty && ovf;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_header         = o_hdr_r;
  assign out_frame_size     = o_size_r;
  assign out_data_capacity  = signed'(o_cap_r);
  assign out_back_pointer   = o_bp_r;
  assign out_pad_previous   = o_padp_r;
  assign out_pad_tail       = o_padt_r;
  assign out_inserted_empty = o_emp_r;
  assign out_last_result    = o_last_r;
  assign out_overflow_flag  = o_ovf_r;

  a_empty_limit: assert property (@(posedge clk) disable iff (!rst_n)
    empties_r <= EMPTY_LIM)
    else $error("inserted empty count beyond limit");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_WAIT)
    else $error("size search finished outside wait state");

  a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> o_size_r != '0)
    else $error("zero frame size on result");

  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_emp_r |-> o_padt_r == '0 && !o_ovf_r && !o_last_r)
    else $error("inserted empty carries tail, overflow or last mark");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !need_empty && last_r |=> acc_r == '0 && bref_r == '0)
    else $error("stream state not cleared after last frame");

endmodule

`default_nettype wire

// ===== sv/cbr_size_div.sv =====
// Bresenham frame size search: restoring divider, one quotient bit per cycle.
// Depends on cbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbr_size_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire cbr_pkg::size_req_t req,
  output logic                   done,
  output cbr_pkg::size_res_t     res
);

  localparam int QW = cbr_pkg::SIZE_W;
  localparam logic [cbr_pkg::CNT_W-1:0] LAST_STEP = cbr_pkg::CNT_W'(QW - 1);

  logic                       busy_r, busy_nxt;
  logic                       fin_r, fin_nxt;
  logic                       done_r, done_nxt;
  logic [cbr_pkg::CNT_W-1:0]  cnt_r;
  logic [cbr_pkg::DEN_W-1:0]  rem_r;
  logic [QW-1:0]              quo_r;
  logic [cbr_pkg::DEN_W-1:0]  den_r;
  cbr_pkg::size_res_t         res_r;

  logic [cbr_pkg::ACC_W:0]    sum;
  logic                       hit;
  logic [cbr_pkg::NUM_W-1:0]  over;
  logic [cbr_pkg::NUM_W-1:0]  dvd;
  logic                       big;
  logic [cbr_pkg::DEN_W:0]    trial;
  logic                       ge;
  logic [cbr_pkg::DEN_W:0]    diff;

  assign sum   = {1'b0, req.acc} + {1'b0, req.den};
  assign hit   = cbr_pkg::NUM_W'(sum) >= req.num;
  assign over  = cbr_pkg::NUM_W'(sum) - req.num;
  assign dvd   = req.num - cbr_pkg::NUM_W'(req.acc) - cbr_pkg::NUM_W'(1);
  assign big   = cbr_pkg::DEN_W'(dvd[cbr_pkg::NUM_W-1:QW]) >= req.den;
  assign trial = {rem_r, quo_r[QW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  assign busy_nxt = start ? (!hit && req.den != '0 && !big) :
                    (busy_r && cnt_r != LAST_STEP);
  assign fin_nxt  = !start && busy_r && cnt_r == LAST_STEP;
  assign done_nxt = (start && !busy_nxt) || fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= req.den;
      cnt_r <= '0;
      rem_r <= cbr_pkg::DEN_W'(dvd[cbr_pkg::NUM_W-1:QW]);
      quo_r <= dvd[QW-1:0];
      if (hit) begin
        res_r.size <= cbr_pkg::SIZE_W'(1);
        res_r.acc  <= over[cbr_pkg::ACC_W] ? '1 : over[cbr_pkg::ACC_W-1:0];
      end else begin
        res_r.size <= cbr_pkg::SIZE_MAX;
        res_r.acc  <= '0;
      end
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      rem_r <= ge ? diff[cbr_pkg::DEN_W-1:0] : trial[cbr_pkg::DEN_W-1:0];
      quo_r <= {quo_r[QW-2:0], ge};
    end else if (fin_r) begin
      if (quo_r == cbr_pkg::SIZE_MAX) begin
        res_r.size <= cbr_pkg::SIZE_MAX;
        res_r.acc  <= '0;
      end else begin
        res_r.size <= quo_r + 1'b1;
        res_r.acc  <= den_r - rem_r - 1'b1;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

`default_nettype wire
